// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the device table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dkdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Device table package
// Widths, opcodes, status codes and the types passed along the cell chain.
// ----------------------------------------------------------------------------
package dkdt_pkg;

   localparam int POS_W     = 8;
   localparam int LONG_W    = 64;
   localparam int SHORT_W   = 16;
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;
   localparam int IDX_OUT_W = 7;
   localparam int CNT_OUT_W = 8;

   localparam int DEF_MAX_ENTRIES = 128;
   localparam int DEF_HASH_SLOTS  = 256;

   localparam logic [OP_W-1:0] OP_FIND_LONG  = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND_SHORT = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD        = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_IDX    = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_LONG   = 3'd4;
   localparam logic [OP_W-1:0] OP_REWRITE    = 3'd5;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   // query travelling down the chain, gathering the hit and the last entry
   typedef struct packed {
      logic               live;
      logic [OP_W-1:0]    opcode;
      logic [LONG_W-1:0]  long_key;
      logic [SHORT_W-1:0] short_key;
      logic [POS_W-1:0]   target;
      logic               found;
      logic [POS_W-1:0]   hit_pos;
      logic [LONG_W-1:0]  hit_long;
      logic [SHORT_W-1:0] hit_short;
      logic [LONG_W-1:0]  last_long;
      logic [SHORT_W-1:0] last_short;
   } tok_type;

   // broadcast write to one cell
   typedef struct packed {
      logic               long_en;
      logic               short_en;
      logic [POS_W-1:0]   pos;
      logic [LONG_W-1:0]  long_val;
      logic [SHORT_W-1:0] short_val;
   } wr_type;

   typedef struct packed {
      logic [ST_W-1:0]      status;
      logic [IDX_OUT_W-1:0] hit_index;
      logic [LONG_W-1:0]    hit_long_key;
      logic [SHORT_W-1:0]   hit_short_key;
      logic [CNT_OUT_W-1:0] entry_count;
   } res_type;

endpackage

// ===== design/dkdt_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table operation per item.
// ----------------------------------------------------------------------------
interface dkdt_req_if;
   import dkdt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [LONG_W-1:0]  long_key;
   logic [SHORT_W-1:0] short_key;
   logic [IDX_OUT_W-1:0] entry_index;

   modport source (output valid, opcode, long_key, short_key, entry_index, input ready);
   modport sink   (input valid, opcode, long_key, short_key, entry_index, output ready);
endinterface

// ===== design/dkdt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one operation result per item.
// ----------------------------------------------------------------------------
interface dkdt_rsp_if;
   import dkdt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ST_W-1:0]      status;
   logic [IDX_OUT_W-1:0] hit_index;
   logic [LONG_W-1:0]    hit_long_key;
   logic [SHORT_W-1:0]   hit_short_key;
   logic [CNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, hit_index, hit_long_key, hit_short_key,
                   entry_count, input ready);
   modport sink   (input valid, status, hit_index, hit_long_key, hit_short_key,
                   entry_count, output ready);
endinterface

// ===== design/dkdt_cell.sv =====
// ----------------------------------------------------------------------------
// Device table cell
// Holds one entry, matches the passing query against it and forwards the
// query, registered, to the next cell.
// ----------------------------------------------------------------------------
module dkdt_cell import dkdt_pkg::*; #(
   parameter int CELL_POS   = 0,
   parameter int HASH_SLOTS = DEF_HASH_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [POS_W-1:0] used_count,
   input  wr_type           wr,
   input  tok_type          up_tok,
   output tok_type          down_tok
);

   localparam logic [POS_W-1:0] MY_POS   = POS_W'(CELL_POS);
   localparam logic [POS_W-1:0] NEXT_POS = POS_W'(CELL_POS + 1);
   // entries beyond the slot count never make it into a lookup index
   localparam bit INDEXED = (CELL_POS < HASH_SLOTS);

   logic [LONG_W-1:0]  long_ff,  long_in;
   logic [SHORT_W-1:0] short_ff, short_in;
   tok_type            tok_ff,   tok_in;
   logic               live_ff,  live_in;
   logic               occupied;
   logic               hit;

   always_comb begin
      occupied = (MY_POS < used_count);
      case (up_tok.opcode)
         OP_FIND_LONG:  hit = occupied && INDEXED && (long_ff == up_tok.long_key);
         OP_FIND_SHORT: hit = occupied && INDEXED && (short_ff == up_tok.short_key);
         OP_DEL_IDX,
         OP_REWRITE:    hit = occupied && (up_tok.target == MY_POS);
         OP_DEL_LONG:   hit = occupied && (long_ff == up_tok.long_key);
         default:       hit = 1'b0;
      endcase

      tok_in  = up_tok;
      live_in = up_tok.live;
      if (up_tok.live && !up_tok.found && hit) begin
         tok_in.found     = 1'b1;
         tok_in.hit_pos   = MY_POS;
         tok_in.hit_long  = long_ff;
         tok_in.hit_short = short_ff;
      end
      if (up_tok.live && (used_count == NEXT_POS)) begin
         tok_in.last_long  = long_ff;
         tok_in.last_short = short_ff;
      end

      long_in  = long_ff;
      short_in = short_ff;
      if (wr.long_en && (wr.pos == MY_POS)) begin
         long_in = wr.long_val;
      end
      if (wr.short_en && (wr.pos == MY_POS)) begin
         short_in = wr.short_val;
      end
   end

   always_ff @(posedge clock) begin
      long_ff  <= long_in;
      short_ff <= short_in;
      tok_ff   <= tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   always_comb begin
      down_tok      = tok_ff;
      down_tok.live = live_ff;
   end

endmodule

// ===== design/dual_key_device_table.sv =====
// ----------------------------------------------------------------------------
// Dual-key device table
// Entry table of long/short address pairs held in a chain of cells; finds
// return the lowest matching position, removals move the last entry in.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req_bus   in   valid/ready          opcode, long_key, short_key, entry_index
//  rsp_bus   out  valid/ready          status, hit_index, hit_long_key,
//                                      hit_short_key, entry_count
//
//  Finds, removals and rewrites send the query down the cell chain, one
//  cell per cycle. Add, range errors and unknown opcodes skip the chain and
//  go straight to the result. One item is in flight at a time.
//  Reset empties the table at once and holds the request side off. A waiting
//  result holds the next result back, not the next request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_key_device_table import dkdt_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int HASH_SLOTS  = DEF_HASH_SLOTS
) (
   input logic        clock,
   input logic        reset,
   dkdt_req_if.sink   req_bus,
   dkdt_rsp_if.source rsp_bus
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] used_ff,  used_in;
   res_type          pend_ff,  pend_in;
   res_type          rsp_ff,   rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic    accept;
   logic    load;
   tok_type head;
   tok_type tail;
   wr_type  wr;
   tok_type chain [MAX_ENTRIES+1];

   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign accept        = req_bus.valid && req_bus.ready;

   assign chain[0] = head;
   assign tail     = chain[MAX_ENTRIES];

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      dkdt_cell #(
         .CELL_POS   (k),
         .HASH_SLOTS (HASH_SLOTS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .used_count (used_ff),
         .wr         (wr),
         .up_tok     (chain[k]),
         .down_tok   (chain[k+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      pend_in  = pend_ff;
      wr       = '0;

      head           = '0;
      head.opcode    = req_bus.opcode;
      head.long_key  = req_bus.long_key;
      head.short_key = req_bus.short_key;
      head.target    = POS_W'(req_bus.entry_index);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in             = '0;
               pend_in.status      = ST_MISS;
               pend_in.entry_count = CNT_OUT_W'(used_ff);
               state_in            = S_DONE;
               case (req_bus.opcode)
                  OP_ADD: begin
                     if (used_ff >= MAX_POS) begin
                        pend_in.status = ST_FULL;
                     end else begin
                        wr.long_en          = 1'b1;
                        wr.short_en         = 1'b1;
                        wr.pos              = used_ff;
                        wr.long_val         = req_bus.long_key;
                        wr.short_val        = req_bus.short_key;
                        used_in             = used_ff + POS_W'(1);
                        pend_in.status      = ST_OK;
                        pend_in.hit_index   = used_ff[IDX_OUT_W-1:0];
                        pend_in.entry_count = CNT_OUT_W'(used_in);
                     end
                  end
                  OP_DEL_IDX,
                  OP_REWRITE: begin
                     if (POS_W'(req_bus.entry_index) >= used_ff) begin
                        pend_in.status = ST_RANGE;
                     end else begin
                        head.live = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  OP_FIND_LONG,
                  OP_FIND_SHORT,
                  OP_DEL_LONG: begin
                     head.live = 1'b1;
                     state_in  = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (tail.live) begin
               state_in            = S_DONE;
               pend_in             = '0;
               pend_in.status      = ST_MISS;
               pend_in.entry_count = CNT_OUT_W'(used_ff);
               if (tail.found) begin
                  pend_in.status        = ST_OK;
                  pend_in.hit_index     = tail.hit_pos[IDX_OUT_W-1:0];
                  pend_in.hit_long_key  = tail.hit_long;
                  pend_in.hit_short_key = tail.hit_short;
               end
               case (tail.opcode)
                  OP_DEL_IDX,
                  OP_DEL_LONG: begin
                     if (tail.found) begin
                        if (tail.hit_pos < used_ff - POS_W'(1)) begin
                           wr.long_en   = 1'b1;
                           wr.short_en  = 1'b1;
                           wr.pos       = tail.hit_pos;
                           wr.long_val  = tail.last_long;
                           wr.short_val = tail.last_short;
                        end
                        used_in             = used_ff - POS_W'(1);
                        pend_in.entry_count = CNT_OUT_W'(used_in);
                     end
                  end
                  OP_REWRITE: begin
                     wr.short_en           = 1'b1;
                     wr.pos                = tail.target;
                     wr.short_val          = tail.short_key;
                     pend_in.hit_short_key = tail.short_key;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output item register
   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (load) begin
         rsp_in       = pend_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.hit_index     = rsp_ff.hit_index;
   assign rsp_bus.hit_long_key  = rsp_ff.hit_long_key;
   assign rsp_bus.hit_short_key = rsp_ff.hit_short_key;
   assign rsp_bus.entry_count   = rsp_ff.entry_count;

   `ASSERT_NOW(a_count_bound, clock, reset, 1'b1, used_ff <= MAX_POS, "entry count above limit")
   `ASSERT_NOW(a_tail_in_scan, clock, reset, tail.live, state_ff == S_SCAN, "query left chain outside scan")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE, "accepted item left no work")
   `ASSERT_NEXT(a_count_step, clock, reset, 1'b1, (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + POS_W'(1)) || (used_ff == $past(used_ff) - POS_W'(1)), "entry count jumped")

endmodule

// ===== bench/tb_dual_key_device_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-key device table testbench
// Sends table operations over the request channel and checks every result
// against a local copy of the table, in which a find or a removal by long
// key takes the lowest matching position and a removal moves the last
// entry into the hole. Directed cases come first. Random traffic then fills
// and drains the table, holds the result side off, and mixes all opcodes
// with keys reused from the table so that finds hit and duplicates occur.
// ----------------------------------------------------------------------------
module tb_dual_key_device_table;
   import dkdt_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX  = 10;
   localparam int IDLE_PCT    = 28;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic clock;
   logic reset;

   dkdt_req_if req_bus ();
   dkdt_rsp_if rsp_bus ();

   dual_key_device_table i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // local copy of the table
   logic [LONG_W-1:0]  long_tab  [TABLE_DEPTH];
   logic [SHORT_W-1:0] short_tab [TABLE_DEPTH];
   int                 fill;

   logic [LONG_W-1:0]  long_pool  [16];
   logic [SHORT_W-1:0] short_pool [16];

   res_type outcomes_due [$];
   int      errors;
   int      mismatches;
   int      idle_pct;
   int      hold_left;
   bit      hold_kick;
   int      cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_dual_key_device_table: errors");
         $finish;
      end
   end

   function automatic void drop_entry(input int pos);
      if (pos + 1 < fill) begin
         long_tab[pos]  = long_tab[fill-1];
         short_tab[pos] = short_tab[fill-1];
      end
      fill--;
   endfunction

   function automatic res_type table_outcome(input logic [OP_W-1:0]      op,
                                             input logic [LONG_W-1:0]    lk,
                                             input logic [SHORT_W-1:0]   sk,
                                             input logic [IDX_OUT_W-1:0] ix);
      res_type r;
      int      pos;
      r = '0;
      r.status = ST_MISS;
      pos = -1;
      case (op)
         OP_FIND_LONG, OP_FIND_SHORT, OP_DEL_LONG: begin
            for (int i = 0; i < fill && pos < 0; i++) begin
               if (op == OP_FIND_SHORT ? short_tab[i] == sk : long_tab[i] == lk)
                  pos = i;
            end
            if (pos >= 0) begin
               r.status        = ST_OK;
               r.hit_index     = IDX_OUT_W'(pos);
               r.hit_long_key  = long_tab[pos];
               r.hit_short_key = short_tab[pos];
               if (op == OP_DEL_LONG)
                  drop_entry(pos);
            end
         end
         OP_ADD: begin
            if (fill >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               long_tab[fill]  = lk;
               short_tab[fill] = sk;
               r.status        = ST_OK;
               r.hit_index     = IDX_OUT_W'(fill);
               fill++;
            end
         end
         OP_DEL_IDX, OP_REWRITE: begin
            if (int'(ix) >= fill) begin
               r.status = ST_RANGE;
            end else begin
               if (op == OP_REWRITE)
                  short_tab[ix] = sk;
               r.status        = ST_OK;
               r.hit_index     = ix;
               r.hit_long_key  = long_tab[ix];
               r.hit_short_key = short_tab[ix];
               if (op == OP_DEL_IDX)
                  drop_entry(int'(ix));
            end
         end
         default: ;
      endcase
      r.entry_count = CNT_OUT_W'(fill);
      return r;
   endfunction

   task automatic send_item(input logic [OP_W-1:0]      op,
                            input logic [LONG_W-1:0]    lk,
                            input logic [SHORT_W-1:0]   sk,
                            input logic [IDX_OUT_W-1:0] ix);
      @(negedge clock);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.long_key    <= lk;
      req_bus.short_key   <= sk;
      req_bus.entry_index <= ix;
      do @(posedge clock); while (!req_bus.ready);
      outcomes_due.push_back(table_outcome(op, lk, sk, ix));
   endtask

   always @(negedge clock) begin
      if (hold_kick) begin
         hold_kick = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      res_type got;
      res_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status        = rsp_bus.status;
         got.hit_index     = rsp_bus.hit_index;
         got.hit_long_key  = rsp_bus.hit_long_key;
         got.hit_short_key = rsp_bus.hit_short_key;
         got.entry_count   = rsp_bus.entry_count;
         if (outcomes_due.size() == 0) begin
            errors++;
            if (mismatches++ < REPORT_MAX)
               $display("unexpected result: st %0d idx %0d long %h short %h cnt %0d",
                        got.status, got.hit_index, got.hit_long_key,
                        got.hit_short_key, got.entry_count);
         end else begin
            exp = outcomes_due.pop_front();
            if (got.status !== exp.status || got.hit_index !== exp.hit_index ||
                got.hit_long_key !== exp.hit_long_key ||
                got.hit_short_key !== exp.hit_short_key ||
                got.entry_count !== exp.entry_count) begin
               errors++;
               if (mismatches++ < REPORT_MAX)
                  $display("mismatch: exp st %0d idx %0d long %h short %h cnt %0d / got st %0d idx %0d long %h short %h cnt %0d",
                           exp.status, exp.hit_index, exp.hit_long_key,
                           exp.hit_short_key, exp.entry_count,
                           got.status, got.hit_index, got.hit_long_key,
                           got.hit_short_key, got.entry_count);
            end
         end
      end
   end

   function automatic logic [LONG_W-1:0] pick_long();
      int unsigned roll;
      roll = $urandom_range(99);
      if (fill > 0 && roll < 40)
         return long_tab[$urandom_range(fill - 1)];
      if (roll < 75)
         return long_pool[$urandom_range(15)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SHORT_W-1:0] pick_short();
      int unsigned roll;
      roll = $urandom_range(99);
      if (fill > 0 && roll < 40)
         return short_tab[$urandom_range(fill - 1)];
      if (roll < 75)
         return short_pool[$urandom_range(15)];
      return SHORT_W'($urandom);
   endfunction

   function automatic logic [IDX_OUT_W-1:0] pick_index();
      if (fill > 0 && $urandom_range(99) < 75)
         return IDX_OUT_W'($urandom_range(fill - 1));
      return IDX_OUT_W'($urandom_range(TABLE_DEPTH - 1));
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input bit grow);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < (grow ? 40 : 12))
         return OP_ADD;
      roll = $urandom_range(99);
      if (roll < 25) return OP_FIND_LONG;
      if (roll < 45) return OP_FIND_SHORT;
      if (roll < 62) return OP_DEL_IDX;
      if (roll < 79) return OP_DEL_LONG;
      if (roll < 94) return OP_REWRITE;
      return roll[0] ? OP_SPARE_A : OP_SPARE_B;
   endfunction

   task automatic send_random(input logic [OP_W-1:0] op);
      send_item(op, pick_long(), pick_short(), pick_index());
   endtask

   task automatic test_empty_table();
      send_item(OP_FIND_LONG, '0, '0, '0);
      send_item(OP_FIND_SHORT, '1, '1, '1);
      send_item(OP_DEL_IDX, '0, '0, '0);
      send_item(OP_REWRITE, '0, 16'h5555, '0);
      send_item(OP_DEL_LONG, '1, '0, '0);
   endtask

   task automatic test_keys_and_duplicates();
      send_item(OP_ADD, '0, '0, '0);
      send_item(OP_ADD, '1, '1, '0);
      send_item(OP_ADD, '1, 16'h1234, '1);
      send_item(OP_ADD, 64'h8000_0000_0000_0000, '0, '0);
      send_item(OP_FIND_LONG, '1, '0, '0);
      send_item(OP_FIND_SHORT, '1, '0, '0);
      send_item(OP_FIND_SHORT, '0, '1, '0);
      send_item(OP_FIND_LONG, 64'h0123_4567_89ab_cdef, '0, '0);
   endtask

   task automatic test_removal_and_rewrite();
      send_item(OP_REWRITE, '0, 16'haaaa, 7'd1);
      send_item(OP_FIND_SHORT, '0, '1, '0);
      send_item(OP_FIND_SHORT, '0, 16'haaaa, '0);
      send_item(OP_DEL_IDX, '0, '0, 7'd0);
      send_item(OP_FIND_LONG, '0, '0, '0);
      send_item(OP_DEL_LONG, '1, '0, '0);
      send_item(OP_REWRITE, '0, 16'h7777, IDX_OUT_W'(fill));
      send_item(OP_DEL_IDX, '0, '0, '1);
   endtask

   task automatic test_unknown_ops();
      send_item(OP_SPARE_A, '1, '1, '1);
      send_item(OP_SPARE_B, '1, '1, '0);
   endtask

   task automatic test_fill_and_drain();
      while (fill < TABLE_DEPTH) begin
         if ($urandom_range(9) == 0)
            send_random($urandom_range(1) ? OP_FIND_LONG : OP_FIND_SHORT);
         else
            send_random(OP_ADD);
      end
      repeat (3) send_random(OP_ADD);
      send_item(OP_REWRITE, pick_long(), pick_short(), IDX_OUT_W'(TABLE_DEPTH - 1));
      send_item(OP_FIND_SHORT, '0, short_tab[TABLE_DEPTH-1], '0);
      send_item(OP_DEL_IDX, '0, '0, IDX_OUT_W'(TABLE_DEPTH - 1));
      send_random(OP_ADD);
      while (fill > 0) begin
         case ($urandom_range(9))
            0, 1:    send_random($urandom_range(1) ? OP_FIND_LONG : OP_FIND_SHORT);
            2, 3, 4: send_random(OP_DEL_LONG);
            default: send_random(OP_DEL_IDX);
         endcase
      end
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      hold_kick = 1'b1;
      repeat (24) begin
         case ($urandom_range(5))
            0:       send_random(OP_FIND_LONG);
            1:       send_item(OP_DEL_IDX, '0, '0, '1);
            2:       send_item(OP_SPARE_A, '0, '0, '0);
            default: send_random(OP_ADD);
         endcase
      end
      idle_pct = IDLE_PCT;
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < 1050; n++) begin
         idle_pct = (n >= 300 && n < 500) ? 0 : IDLE_PCT;
         send_random(pick_op((n / 100) % 2 == 0));
      end
      idle_pct = IDLE_PCT;
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.long_key     = '0;
      req_bus.short_key    = '0;
      req_bus.entry_index  = '0;
      rsp_bus.ready        = 1'b0;
      fill       = 0;
      errors     = 0;
      mismatches = 0;
      cycles     = 0;
      hold_left  = 0;
      hold_kick  = 1'b0;
      idle_pct   = IDLE_PCT;
      long_pool[0]  = '0;
      long_pool[1]  = '1;
      long_pool[2]  = 64'h8000_0000_0000_0000;
      long_pool[3]  = 64'h1;
      short_pool[0] = '0;
      short_pool[1] = '1;
      short_pool[2] = 16'h8000;
      short_pool[3] = 16'h1;
      for (int i = 4; i < 16; i++) begin
         long_pool[i]  = {$urandom, $urandom};
         short_pool[i] = SHORT_W'($urandom);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_keys_and_duplicates();
      test_removal_and_rewrite();
      test_unknown_ops();
      test_fill_and_drain();
      test_backpressure();
      test_random_mix();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outcomes_due.size() > 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);

      if (errors == 0)
         $display("tb_dual_key_device_table: clean");
      else
         $display("tb_dual_key_device_table: errors");
      $finish;
   end

endmodule
